// ===== rtl/ple_pkg.sv =====
// ple_pkg: shared types and codes for the positional list engine
// request and result structs, operation and status codes, sequencer states
// no dependencies

package ple_pkg;

  // operation codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_DEL_POS   = 3'd5;
  localparam logic [2:0] OP_READ_ALL  = 3'd6;
  localparam logic [2:0] OP_COUNT     = 3'd7;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [5:0]         element_count;
    logic               last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_MV,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_MV,
    S_DEL_FIN,
    S_RO_RD
  } state_t;

endpackage

// ===== rtl/positional_list_engine.sv =====
// positional_list_engine: ordered list of signed 32-bit values in an element memory
// one sequencer moves elements one at a time through the memory's read and write ports
// depends on ple_pkg

// Usage: raise start with a request while busy is low; the request is taken at that edge
// and busy rises the next cycle for any operation that walks the memory. Results leave on
// result, each marked by done for exactly one cycle; the receiver cannot hold them off, so
// it must take every result as it appears. Timing is set by the element memory, which
// moves one element at a time (registered read, then write). The steps:
//   insert at index k: cells from the back down to k each move one cell back, then the
//   new value is written at k and the result follows
//   delete at index k: cells after k each move one cell forward, then the length drops
//   and the result follows; read-out of n elements: each is read, then emitted, n results
//   count, errors, empty read-out: one result, busy stays low
// A full list rejects inserts with status full; deletes on an empty list report empty.
// Memory contents are not cleared at reset; only cells below the length are ever read.

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  // length must hold CAPACITY itself, memory index only CAPACITY-1
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  // element memory, one write and one registered read port
  logic signed [31:0] mem [CAPACITY];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  // sequencer and datapath registers
  state_t             state, state_next;
  logic [LW-1:0]      length, length_next;
  logic [LW-1:0]      cnt, cnt_next;
  logic [LW-1:0]      idx, idx_next;
  logic signed [31:0] val_r, val_next;
  logic               done_next;
  rsp_t               result_next;

  // read-out phase toggle: a cell is read in one phase and its data is emitted in the next
  logic ro_emit, ro_emit_next;
  logic ro_last;

  // decode of the incoming request
  logic          accept;
  logic          is_ins, is_del;
  logic          ins_bad, del_bad;
  logic          full, empty;
  logic [LW-1:0] ins_idx, del_idx;
  logic [8:0]    pos9, len9;
  logic [LW-1:0] pos_dec;
  logic [LW:0]   del_idx_inc;

  // step helpers for the walking counter
  logic [LW-1:0] cnt_dec, cnt_inc;
  logic [LW:0]   cnt_inc2;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign cnt_dec = cnt - 1'b1;
  assign cnt_inc = cnt + 1'b1;
  assign cnt_inc2 = {1'b0, cnt} + (LW+1)'(2);
  assign ro_last = (cnt_inc == length);

  always_comb begin
    pos9    = {1'b0, request.position};
    len9    = 9'(length);
    pos_dec = LW'(pos9 - 9'd1);
    full    = (length >= LW'(CAPACITY));
    empty   = (length == '0);
    is_ins  = 1'b0;
    is_del  = 1'b0;
    case (request.operation) inside
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: is_ins = 1'b1;
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: is_del = 1'b1;
      default: ;
    endcase
    // positional range checks, insert allows one past the end
    ins_bad = (request.operation == OP_INS_POS) &&
              ((pos9 == 9'd0) || (pos9 > (len9 + 9'd1)));
    del_bad = (request.operation == OP_DEL_POS) &&
              ((pos9 == 9'd0) || (pos9 > len9));
    unique case (request.operation)
      OP_INS_FRONT: ins_idx = '0;
      OP_INS_BACK:  ins_idx = length;
      default:      ins_idx = pos_dec;
    endcase
    unique case (request.operation)
      OP_DEL_FRONT: del_idx = '0;
      OP_DEL_BACK:  del_idx = length - 1'b1;
      default:      del_idx = pos_dec;
    endcase
    del_idx_inc = {1'b0, del_idx} + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_ins && !ins_bad && !full) begin
            state_next = (length > ins_idx) ? S_INS_RD : S_INS_PUT;
          end else if (is_del && !empty && !del_bad) begin
            state_next = (del_idx_inc < {1'b0, length}) ? S_DEL_RD : S_DEL_FIN;
          end else if ((request.operation == OP_READ_ALL) && !empty) begin
            state_next = S_RO_RD;
          end
        end
      end
      S_INS_RD:  state_next = S_INS_MV;
      S_INS_MV:  state_next = (cnt_dec > idx) ? S_INS_RD : S_INS_PUT;
      S_INS_PUT: state_next = S_IDLE;
      S_DEL_RD:  state_next = S_DEL_MV;
      S_DEL_MV:  state_next = (cnt_inc2 < {1'b0, length}) ? S_DEL_RD : S_DEL_FIN;
      S_DEL_FIN: state_next = S_IDLE;
      S_RO_RD: begin
        // read-out alternates between reading a cell and emitting it
        state_next = S_RO_RD;
      end
      default:   state_next = S_IDLE;
    endcase
    if ((state == S_RO_RD) && ro_emit && ro_last) begin
      state_next = S_IDLE;
    end
  end

  // outputs and datapath
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = cnt[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = cnt[AW-1:0];
    length_next  = length;
    cnt_next     = cnt;
    idx_next     = idx;
    val_next     = val_r;
    ro_emit_next = 1'b0;
    done_next    = 1'b0;
    result_next  = '{status: STAT_OK, element: '0, element_count: '0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          val_next = request.value;
          if (is_ins) begin
            idx_next = ins_idx;
            cnt_next = length;
            if (ins_bad) begin
              done_next          = 1'b1;
              result_next.status = STAT_BADPOS;
            end else if (full) begin
              done_next          = 1'b1;
              result_next.status = STAT_FULL;
            end
          end else if (is_del) begin
            idx_next = del_idx;
            cnt_next = del_idx;
            if (empty) begin
              done_next          = 1'b1;
              result_next.status = STAT_EMPTY;
            end else if (del_bad) begin
              done_next          = 1'b1;
              result_next.status = STAT_BADPOS;
            end
          end else if (request.operation == OP_READ_ALL) begin
            cnt_next = '0;
            if (empty) begin
              done_next          = 1'b1;
              result_next.status = STAT_EMPTY;
            end
          end else begin
            // count
            done_next = 1'b1;
          end
        end
      end
      S_INS_RD: begin
        mem_raddr = cnt_dec[AW-1:0];
      end
      S_INS_MV: begin
        // shift one cell toward the back
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = mem_rdata;
        cnt_next  = cnt_dec;
      end
      S_INS_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = idx[AW-1:0];
        mem_wdata   = val_r;
        length_next = length + 1'b1;
        done_next   = 1'b1;
      end
      S_DEL_RD: begin
        mem_raddr = cnt_inc[AW-1:0];
      end
      S_DEL_MV: begin
        // shift one cell toward the front
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = mem_rdata;
        cnt_next  = cnt_inc;
      end
      S_DEL_FIN: begin
        length_next = length - 1'b1;
        done_next   = 1'b1;
      end
      S_RO_RD: begin
        mem_raddr = cnt[AW-1:0];
        if (ro_emit) begin
          done_next           = 1'b1;
          result_next.element = mem_rdata;
          result_next.last    = ro_last;
          cnt_next            = cnt_inc;
        end else begin
          ro_emit_next = 1'b1;
        end
      end
      default: ;
    endcase
    result_next.element_count = 6'(length_next);
  end

  // element memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_rdata <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      length  <= '0;
      done    <= 1'b0;
      ro_emit <= 1'b0;
    end else begin
      state   <= state_next;
      length  <= length_next;
      done    <= done_next;
      ro_emit <= ro_emit_next;
    end
  end

  // payload and walking registers
  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    idx    <= idx_next;
    val_r  <= val_next;
    result <= result_next;
  end

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for positional_list_engine
// drives list requests, tracks the list in a queue and checks every result
// depends on ple_pkg and rtl/positional_list_engine.sv
`timescale 1ns / 1ps

module tb
  import ple_pkg::*;
();

  localparam int LIST_CAP     = 32;
  localparam int RAND_ITEMS   = 80;
  localparam int TAIL_CYCLES  = 100;   // longer than the longest walk
  localparam int QUIET_LIMIT  = 3000;  // cycles with no request and no result taken

  // one pending request plus how the sender treats it
  typedef struct packed {
    req_t       req;
    logic       drain;    // hold off until every earlier result has come back
    logic [6:0] gap_pct;  // chance per cycle that the sender sits idle
  } pending_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  pending_t                request_q[$];
  rsp_t                    expected_results[$];
  logic signed [31:0]      list_shadow[$];   // the list as the block should hold it
  int                      gen_len;          // list length as seen while generating
  int                      mismatch_count = 0;
  int                      quiet_cycles = 0;
  logic                    took;
  rsp_t                    want;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // list tracking: apply one accepted request to the shadow list and queue the
  // results it should produce
  // ---------------------------------------------------------------------------
  task automatic push_result(input logic [1:0] st, input logic signed [31:0] el,
                             input logic fin);
    rsp_t r;
    r.status        = st;
    r.element       = el;
    r.element_count = 6'(list_shadow.size());
    r.last          = fin;
    expected_results.push_back(r);
  endtask

  task automatic apply_list_op(input req_t r);
    logic [1:0] st;
    int         n;
    st = STAT_OK;
    n  = list_shadow.size();
    case (r.operation)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        // a bad position wins over a full list
        if (r.operation == OP_INS_POS && (r.position == 0 || int'(r.position) > n + 1)) begin
          st = STAT_BADPOS;
        end else if (n >= LIST_CAP) begin
          st = STAT_FULL;
        end else if (r.operation == OP_INS_FRONT) begin
          list_shadow.push_front(r.value);
        end else if (r.operation == OP_INS_BACK) begin
          list_shadow.push_back(r.value);
        end else begin
          list_shadow.insert(int'(r.position) - 1, r.value);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
        // empty wins over a bad position
        if (n == 0) begin
          st = STAT_EMPTY;
        end else if (r.operation == OP_DEL_POS && (r.position == 0 || int'(r.position) > n)) begin
          st = STAT_BADPOS;
        end else if (r.operation == OP_DEL_FRONT) begin
          void'(list_shadow.pop_front());
        end else if (r.operation == OP_DEL_BACK) begin
          void'(list_shadow.pop_back());
        end else begin
          list_shadow.delete(int'(r.position) - 1);
        end
      end
      OP_READ_ALL: begin
        if (n == 0) begin
          st = STAT_EMPTY;
        end else begin
          // one result per element, last flag on the final one
          for (int i = 0; i < n; i++) push_result(STAT_OK, list_shadow[i], i == n - 1);
          return;
        end
      end
      default: ;  // count: status ok, no change
    endcase
    push_result(st, 32'sd0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // request generation: also tracks the list length so that most positions
  // land inside the list
  // ---------------------------------------------------------------------------
  task automatic add_request(input logic [2:0] op, input logic [31:0] val,
                             input logic [7:0] pos, input logic drain,
                             input logic [6:0] gap);
    pending_t p;
    p.req.operation = op;
    p.req.value     = val;
    p.req.position  = pos;
    p.drain         = drain;
    p.gap_pct       = gap;
    request_q.push_back(p);
    case (op)
      OP_INS_FRONT, OP_INS_BACK: if (gen_len < LIST_CAP) gen_len++;
      OP_INS_POS: if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_CAP) gen_len++;
      OP_DEL_FRONT, OP_DEL_BACK: if (gen_len > 0) gen_len--;
      OP_DEL_POS: if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input rsp_t want_r, input rsp_t got_r);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected status %0d element %0d count %0d last %0d",
               $time, what, want_r.status, want_r.element, want_r.element_count, want_r.last);
      $display("%0t: %s: got status %0d element %0d count %0d last %0d",
               $time, what, got_r.status, got_r.element, got_r.element_count, got_r.last);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: a request is taken at an edge with start high and busy low; start
  // stays up until then, and only changes once per edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        apply_list_op(request);
        request_q.delete(0);
      end
      if (took || !start) begin
        // a drain request waits until every earlier result is back
        if (request_q.size() != 0 && !(request_q[0].drain && expected_results.size() != 0)
            && $urandom_range(99) >= request_q[0].gap_pct) begin
          start   <= 1'b1;
          request <= request_q[0].req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: done marks a result for one cycle, it is taken at the edge that
  // ends that cycle; also feeds the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, result);
        end else begin
          want = expected_results.pop_front();
          if (want.status !== result.status || want.element !== result.element ||
              want.element_count !== result.element_count || want.last !== result.last) begin
            report_mismatch("result mismatch", want, result);
          end
        end
      end
    end
  end

  // watchdog: nothing moving for too long ends the run
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [2:0]  ins_ops[3];
    logic [2:0]  del_ops[3];
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] val;
    logic [6:0]  gap;
    int unsigned roll;
    int unsigned ins_pct;
    ins_ops = '{OP_INS_FRONT, OP_INS_BACK, OP_INS_POS};
    del_ops = '{OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS};
    gen_len = 0;

    // directed: count, read-out and every delete on an empty list
    add_request(OP_COUNT,     32'h0, 8'd0,   1'b0, 7'd22);
    add_request(OP_READ_ALL,  32'h0, 8'd0,   1'b0, 7'd22);  // empty read-out
    add_request(OP_DEL_FRONT, 32'h0, 8'd0,   1'b0, 7'd22);
    add_request(OP_DEL_BACK,  32'h0, 8'd0,   1'b0, 7'd22);
    add_request(OP_DEL_POS,   32'h0, 8'd0,   1'b0, 7'd22);  // empty beats bad position
    add_request(OP_DEL_POS,   32'h0, 8'd255, 1'b0, 7'd22);
    // insert positions out of range
    add_request(OP_INS_POS,   32'h1, 8'd0,   1'b0, 7'd22);
    add_request(OP_INS_POS,   32'h1, 8'd2,   1'b0, 7'd22);
    // build a small list with extreme values
    add_request(OP_INS_FRONT, 32'h8000_0000, 8'd0, 1'b0, 7'd22);
    add_request(OP_INS_BACK,  32'h7fff_ffff, 8'd0, 1'b0, 7'd22);
    add_request(OP_INS_POS,   32'h0000_0000, 8'd1, 1'b0, 7'd22);
    add_request(OP_INS_POS,   32'hffff_ffff, 8'd4, 1'b0, 7'd22);  // one past the end
    add_request(OP_INS_POS,   32'h1234_5678, 8'd255, 1'b0, 7'd22);
    add_request(OP_READ_ALL,  32'h0, 8'd0,   1'b0, 7'd22);
    // delete positions out of range on a non-empty list, then deletes down to one element
    add_request(OP_DEL_POS,   32'h0, 8'd0,   1'b0, 7'd22);
    add_request(OP_DEL_POS,   32'h0, 8'd5,   1'b0, 7'd22);
    add_request(OP_DEL_POS,   32'h0, 8'd2,   1'b0, 7'd22);
    add_request(OP_COUNT,     32'h0, 8'd0,   1'b0, 7'd22);
    add_request(OP_DEL_FRONT, 32'h0, 8'd0,   1'b0, 7'd22);
    add_request(OP_DEL_BACK,  32'h0, 8'd0,   1'b0, 7'd22);
    add_request(OP_READ_ALL,  32'h0, 8'd0,   1'b0, 7'd22);  // single element read-out
    add_request(OP_DEL_POS,   32'h0, 8'd1,   1'b0, 7'd22);  // back to empty
    add_request(OP_INS_POS,   32'h5555_5555, 8'd1, 1'b0, 7'd22);
    add_request(OP_INS_POS,   32'haaaa_aaaa, 8'd2, 1'b0, 7'd22);
    add_request(OP_READ_ALL,  32'h0, 8'd0,   1'b0, 7'd22);

    // random: first mostly inserts to fill the list and push on the full
    // case, then mostly deletes, then an even mix
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i < 50) ins_pct = 95;
      else if (i < 70) ins_pct = 5;
      else ins_pct = 50;
      // sender idling: light, then heavy, then none
      if (i < 27) gap = 7'd22;
      else if (i < 54) gap = 7'd54;
      else gap = 7'd0;

      roll = $urandom_range(99);
      if (roll < 8) op = OP_READ_ALL;
      else if (roll < 12) op = OP_COUNT;
      else if ($urandom_range(99) < ins_pct) op = ins_ops[$urandom_range(2)];
      else op = del_ops[$urandom_range(2)];

      // mostly positions inside the list, some anywhere in the field
      if ($urandom_range(9) < 8) begin
        if (op == OP_INS_POS) pos = 8'($urandom_range(gen_len + 1, 1));
        else pos = (gen_len == 0) ? 8'd1 : 8'($urandom_range(gen_len, 1));
      end else begin
        pos = 8'($urandom_range(255));
      end

      case ($urandom_range(15))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'hffff_ffff;
        3: val = 32'h0000_0000;
        default: val = $urandom;
      endcase

      // pause for a full drain now and then
      add_request(op, val, pos, (i == 0 || i == 50 || i == 70), gap);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // every request taken, every result back, then a quiet tail to catch strays
    while (request_q.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== positional_list_engine.f =====
rtl/ple_pkg.sv
rtl/positional_list_engine.sv
test/tb.sv
